[hdl/bmhpq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types, codes and defaults for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int CAPACITY_DEF      = 1024;
  localparam int PRIORITY_BITS_DEF = 32;
  localparam int PAYLOAD_BITS_DEF  = 16;

  // operation codes
  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_DEQ   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] in_priority;
    logic [15:0] in_payload;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_priority;
    logic [15:0] out_payload;
    logic [10:0] count;
  } result_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;       // capture input item
    logic       enq_begin;  // hole at end, count up
    logic       rd_parent;  // read parent of hole
    logic       up_move;    // parent moves down into hole
    logic       rd_top;     // read root and last entry
    logic       take_root;  // latch root for the result
    logic       deq_begin;  // last entry becomes the moving one, count down
    logic       rd_kids;    // read both children of hole
    logic       dn_move;    // chosen child moves up into hole
    logic       put;        // moving entry written into hole
    logic       clr;        // empty the heap
    logic       resp;       // register result
    logic [1:0] status;     // status for the result
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       at_root;
    logic       leaf;
    logic       up_swap;
    logic       dn_swap;
  } flg_t;

endpackage

[hdl/binary_min_heap_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top
// Array-based binary min-heap priority queue: enqueue, dequeue, peek, clear.
//
//   channel   ports                 handshake
//   input     item (item_t)         taken when start & !busy
//   output    result (result_t)     valid for one cycle while done is high
//
// Clear, full and empty are answered from the dispatch state; peek reads the
// root first. Enqueue walks up (sift up) and dequeue walks down (sift down)
// one level per pass, and a walk ends early when a compare stops it; a level
// costs one registered memory read and one compare/write. busy is high after
// acceptance through the done cycle. Reset empties the heap at once; memory
// contents need no clearing. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_top #(
  parameter int CAPACITY      = bmhpq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = bmhpq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = bmhpq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bmhpq_pkg::item_t   item,
  output logic               done,
  output bmhpq_pkg::result_t result
);
  import bmhpq_pkg::*;

  ctl_t ctl;
  flg_t flg;

  // sequencer
  bmhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flg   (flg),
    .ctl   (ctl)
  );

  // heap storage and arithmetic
  bmhpq_dp #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .flg    (flg),
    .result (result),
    .done   (done)
  );

endmodule

[hdl/bmhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Sequencer: walks enqueue sift-up and dequeue sift-down one level per pass.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bmhpq_pkg::flg_t flg,
  output bmhpq_pkg::ctl_t ctl
);
  import bmhpq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_TOP   = 3'd2;
  localparam logic [2:0] S_UPRD  = 3'd3;
  localparam logic [2:0] S_UPCMP = 3'd4;
  localparam logic [2:0] S_DNRD  = 3'd5;
  localparam logic [2:0] S_DNCMP = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    ctl        = '0;
    ctl.status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (flg.mode)
          MODE_ENQ: begin
            if (flg.full) begin
              ctl.resp   = 1'b1;
              ctl.status = ST_FULL;
              state_next = S_OUT;
            end else begin
              ctl.enq_begin = 1'b1;
              state_next    = S_UPRD;
            end
          end
          MODE_DEQ, MODE_PEEK: begin
            if (flg.empty) begin
              ctl.resp   = 1'b1;
              ctl.status = ST_EMPTY;
              state_next = S_OUT;
            end else begin
              ctl.rd_top = 1'b1;
              state_next = S_TOP;
            end
          end
          default: begin
            ctl.clr    = 1'b1;
            ctl.resp   = 1'b1;
            state_next = S_OUT;
          end
        endcase
      end
      S_TOP: begin
        ctl.take_root = 1'b1;
        if (flg.mode == MODE_PEEK) begin
          ctl.resp   = 1'b1;
          state_next = S_OUT;
        end else begin
          ctl.deq_begin = 1'b1;
          state_next    = S_DNRD;
        end
      end
      S_UPRD: begin
        if (flg.at_root) begin
          ctl.put    = 1'b1;
          ctl.resp   = 1'b1;
          state_next = S_OUT;
        end else begin
          ctl.rd_parent = 1'b1;
          state_next    = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (flg.up_swap) begin
          ctl.up_move = 1'b1;
          state_next  = S_UPRD;
        end else begin
          ctl.put    = 1'b1;
          ctl.resp   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DNRD: begin
        if (flg.leaf) begin
          ctl.put    = 1'b1;
          ctl.resp   = 1'b1;
          state_next = S_OUT;
        end else begin
          ctl.rd_kids = 1'b1;
          state_next  = S_DNCMP;
        end
      end
      S_DNCMP: begin
        if (flg.dn_swap) begin
          ctl.dn_move = 1'b1;
          state_next  = S_DNRD;
        end else begin
          ctl.put    = 1'b1;
          ctl.resp   = 1'b1;
          state_next = S_OUT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/bmhpq_dp.sv]
// ----------------------------------------------------------------------------
// bmhpq_dp
// Heap memory, fill count, hole position, moving entry and result register.
// ----------------------------------------------------------------------------
module bmhpq_dp #(
  parameter int CAPACITY      = bmhpq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = bmhpq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = bmhpq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bmhpq_pkg::item_t   item,
  input  bmhpq_pkg::ctl_t    ctl,
  output bmhpq_pkg::flg_t    flg,
  output bmhpq_pkg::result_t result,
  output logic               done
);
  import bmhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;

  // entry = {key, tag}
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_a, rd_b, ent, root;
  logic [EW-1:0] root_src;
  logic [1:0]    mode_q;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] pos;
  logic [AW-1:0] addr_a, addr_b, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  // child and parent indexes
  logic [CW:0]   lc, rc;
  logic [AW-1:0] parent, pick_idx;
  logic [EW-1:0] pick;
  logic          rc_ok;

  assign lc     = (CW + 1)'({pos, 1'b1});
  assign rc     = (CW + 1)'({pos, 1'b1}) + 1'b1;
  assign parent = AW'((pos - 1'b1) >> 1);
  assign rc_ok  = (rc < (CW + 1)'(cnt));

  // right child wins ties
  always_comb begin
    if (rc_ok && !($signed(rd_a[EW-1 -: PRIORITY_BITS]) <
                   $signed(rd_b[EW-1 -: PRIORITY_BITS]))) begin
      pick     = rd_b;
      pick_idx = rc[AW-1:0];
    end else begin
      pick     = rd_a;
      pick_idx = lc[AW-1:0];
    end
  end

  // incoming entry, key sign-extended or cut to the stored width
  logic signed [47:0] key_wide;
  logic [31:0]        tag_wide;
  assign key_wide = 48'($signed(item.in_priority));
  assign tag_wide = 32'(item.in_payload);

  // status to controller
  assign flg.mode    = mode_q;
  assign flg.full    = (cnt == CW'(CAPACITY));
  assign flg.empty   = (cnt == '0);
  assign flg.at_root = (pos == '0);
  assign flg.leaf    = (lc >= (CW + 1)'(cnt));
  assign flg.up_swap = ($signed(rd_a[EW-1 -: PRIORITY_BITS]) >
                        $signed(ent[EW-1 -: PRIORITY_BITS]));
  assign flg.dn_swap = ($signed(pick[EW-1 -: PRIORITY_BITS]) <
                        $signed(ent[EW-1 -: PRIORITY_BITS]));

  // read addresses
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (ctl.rd_parent) addr_a = parent;
    if (ctl.rd_top)    addr_b = AW'(cnt - 1'b1);
    if (ctl.rd_kids) begin
      addr_a = lc[AW-1:0];
      addr_b = rc[AW-1:0];
    end
  end

  // single write port
  always_comb begin
    wr_en   = ctl.up_move | ctl.dn_move | ctl.put;
    wr_addr = pos;
    wr_data = ent;
    if (ctl.up_move) wr_data = rd_a;
    if (ctl.dn_move) wr_data = pick;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // fill count
  always_comb begin
    cnt_next = cnt;
    if (ctl.enq_begin) cnt_next = cnt + 1'b1;
    if (ctl.deq_begin) cnt_next = cnt - 1'b1;
    if (ctl.clr)       cnt_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else     cnt <= cnt_next;
  end

  // moving entry and hole position
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode_q <= item.mode;
      ent    <= {key_wide[PRIORITY_BITS-1:0], tag_wide[PAYLOAD_BITS-1:0]};
      root   <= '0;
    end
    if (ctl.enq_begin) pos <= cnt[AW-1:0];
    if (ctl.up_move)   pos <= parent;
    if (ctl.take_root) root <= rd_a;
    if (ctl.deq_begin) begin
      ent <= rd_b;
      pos <= '0;
    end
    if (ctl.dn_move)   pos <= pick_idx;
  end

  // root as seen by the result, including the cycle it is being read
  assign root_src = ctl.take_root ? rd_a : root;

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ctl.resp;
    if (ctl.resp) begin
      result.status       <= ctl.status;
      result.out_priority <= 32'(root_src[EW-1 -: PRIORITY_BITS]);
      result.out_payload  <= 16'(root_src[PAYLOAD_BITS-1:0]);
      result.count        <= 11'(cnt_next);
    end
  end

endmodule
